// ===== design/kwsv_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsv_pkg
// Shared types and constants for the keyword score vote gate.
// ----------------------------------------------------------------------------
package kwsv_pkg;

  // field widths
  localparam int SCORE_W    = 8;
  localparam int TICK_W     = 32;
  localparam int IDX_W      = 6;
  localparam int CONF_W     = 7;
  localparam int TRIG_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // default keyword count per frame
  localparam int NUM_KEYWORDS_DEF = 8;

  // register reset values
  localparam logic [SCORE_W-1:0] THRESH_RESET   = 8'd82;
  localparam logic [TRIG_W-1:0]  TRIGGER_RESET  = 4'd3;
  localparam logic [TICK_W-1:0]  COOLDOWN_RESET = 32'd1000;

  // confidence scaling
  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam logic [6:0] PCT_ROUND = 7'd127;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TRIGGER   = 2'd1,
    REG_COOLDOWN  = 2'd2
  } cfg_reg_t;

  // timestamp table write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] tick;
  } ts_write_t;

endpackage

// ===== design/keyword_score_vote_gate.sv =====
// ----------------------------------------------------------------------------
// keyword_score_vote_gate
// Frame argmax, consecutive-frame vote, threshold and per-keyword cooldown.
// ----------------------------------------------------------------------------
// One score beat is taken every clock cycle while s_tready is high; a frame
// is NUM_KEYWORDS beats, keyword 0 first, and the now_tick of the frame's
// last beat is the time used. The last beat of a frame registers its result
// in the timestamp stage and reads the keyword's last-fire timestamp from the
// table memory; loading the output register does the 32-bit wrap-safe elapsed
// compare and writes the new timestamp back on a firing. s_tready drops only
// while both the timestamp stage and the output register hold a result that
// m_tready has not taken. After reset every timestamp reads as zero through
// per-entry valid bits, so no clearing pass is needed. Cfg port writes of
// threshold and trigger apply at the next frame end, cooldown at output load.
module keyword_score_vote_gate #(
  parameter int NUM_KEYWORDS = kwsv_pkg::NUM_KEYWORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // cfg write port
  input  logic                            cfg_we,
  input  logic [kwsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kwsv_pkg::CFG_DATA_W-1:0] cfg_data,
  // score stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [39:0]                     s_tdata,  // score[7:0], now_tick[39:8]
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata   // top_index[5:0], top_score[13:6],
                                                    // detected[14], fired[15],
                                                    // score_pct[22:16], zero[23]
);
  import kwsv_pkg::*;

  localparam int POS_W = $clog2(NUM_KEYWORDS);
  localparam int AW    = $clog2(NUM_KEYWORDS);

  // configuration registers
  logic [SCORE_W-1:0] score_threshold;
  logic [TRIG_W-1:0]  trigger_count;
  logic [TICK_W-1:0]  cooldown_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= THRESH_RESET;
      trigger_count   <= TRIGGER_RESET;
      cooldown_ticks  <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: score_threshold <= cfg_data[SCORE_W-1:0];
        REG_TRIGGER:   trigger_count   <= cfg_data[TRIG_W-1:0];
        REG_COOLDOWN:  cooldown_ticks  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [SCORE_W-1:0] score;
  logic [TICK_W-1:0]  now_tick;
  assign score    = s_tdata[7:0];
  assign now_tick = s_tdata[39:8];

  // pipeline control
  logic s1_valid;
  logic out_load;
  logic stall;
  logic in_beat;
  logic last_beat;
  logic frame_end;

  assign stall     = s1_valid && m_tvalid && !m_tready;
  assign s_tready  = !stall;
  assign in_beat   = s_tvalid && s_tready;
  assign out_load  = s1_valid && (!m_tvalid || m_tready);

  // running argmax over the frame
  logic [POS_W-1:0]   pos;
  logic [SCORE_W-1:0] running_max;
  logic [IDX_W-1:0]   running_index;
  logic [SCORE_W-1:0] cur_max;
  logic [IDX_W-1:0]   cur_idx;
  logic [SCORE_W-1:0] mx;
  logic [IDX_W-1:0]   ix;

  assign last_beat = (pos == POS_W'(NUM_KEYWORDS - 1));
  assign frame_end = in_beat && last_beat;

  always_comb begin
    cur_max = (pos == '0) ? '0 : running_max;
    cur_idx = (pos == '0) ? '0 : running_index;
    if (score > cur_max) begin
      mx = score;
      ix = IDX_W'(pos);
    end else begin
      mx = cur_max;
      ix = cur_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      running_max   <= '0;
      running_index <= '0;
    end else if (in_beat) begin
      pos           <= last_beat ? '0 : pos + POS_W'(1);
      running_max   <= mx;
      running_index <= ix;
    end
  end

  // vote over consecutive frames
  logic [IDX_W-1:0]  vote_target;
  logic              vote_started;
  logic [TRIG_W-1:0] vote_count;
  logic [IDX_W-1:0]  vote_target_next;
  logic              vote_started_next;
  logic [TRIG_W-1:0] vote_count_next;
  logic [TRIG_W-1:0] count_inc;
  logic              detect;

  assign count_inc = vote_count + TRIG_W'(1);

  always_comb begin
    vote_target_next  = vote_target;
    vote_started_next = vote_started;
    vote_count_next   = vote_count;
    detect            = 1'b0;
    if (!vote_started || ix == vote_target) begin
      if (!vote_started) begin
        vote_target_next  = ix;
        vote_started_next = 1'b1;
      end
      if (count_inc >= trigger_count) begin
        vote_count_next   = '0;
        vote_started_next = 1'b0;
        detect            = (ix != '0) && (mx >= score_threshold);
      end else begin
        vote_count_next = count_inc;
      end
    end else begin
      vote_count_next  = TRIG_W'(1);
      vote_target_next = ix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_target  <= '0;
      vote_started <= 1'b0;
      vote_count   <= '0;
    end else if (frame_end) begin
      vote_target  <= vote_target_next;
      vote_started <= vote_started_next;
      vote_count   <= vote_count_next;
    end
  end

  // timestamp stage registers
  logic [IDX_W-1:0]   s1_ix;
  logic [SCORE_W-1:0] s1_mx;
  logic               s1_det;
  logic [TICK_W-1:0]  s1_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= frame_end || (s1_valid && !out_load);
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      s1_ix  <= ix;
      s1_mx  <= mx;
      s1_det <= detect;
      s1_now <= now_tick;
    end
  end

  // timestamp table
  ts_write_t         ts_wr;
  logic [TICK_W-1:0] last_tick;
  logic [TICK_W-1:0] elapsed;
  logic              fire;

  assign elapsed = s1_now - last_tick;
  assign fire    = s1_det && (elapsed >= cooldown_ticks);

  always_comb begin
    ts_wr.en   = out_load && fire;
    ts_wr.idx  = s1_ix;
    ts_wr.tick = s1_now;
  end

  kwsv_ts_mem #(
    .DEPTH (NUM_KEYWORDS),
    .AW    (AW)
  ) u_ts_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (ts_wr),
    .rd_en   (frame_end),
    .rd_idx  (ix),
    .rd_tick (last_tick)
  );

  // rounded percentage: (mx*100+127)/255 via reciprocal
  logic [14:0] pct_num;
  logic [15:0] pct_sum;
  logic [CONF_W-1:0] conf;

  assign pct_num = 15'(s1_mx) * 15'(PCT_SCALE) + 15'(PCT_ROUND);
  assign pct_sum = 16'(pct_num) + 16'(pct_num[14:8]) + 16'd1;
  assign conf    = pct_sum[14:8];

  // output register
  logic [IDX_W-1:0]   top_index;
  logic [SCORE_W-1:0] top_score;
  logic               detected;
  logic               fired;
  logic [CONF_W-1:0]  score_pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_index <= s1_ix;
      top_score <= s1_mx;
      detected  <= s1_det;
      fired     <= fire;
      score_pct <= conf;
    end
  end

  assign m_tdata = {1'b0, score_pct, fired, detected, top_score, top_index};

endmodule

// ===== design/kwsv_ts_mem.sv =====
// ----------------------------------------------------------------------------
// kwsv_ts_mem
// Per-keyword last-fire timestamp table: one write and one registered read
// per cycle, with same-cycle write-to-read bypass and per-entry valid bits so
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module kwsv_ts_mem #(
  parameter int DEPTH = kwsv_pkg::NUM_KEYWORDS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kwsv_pkg::ts_write_t         wr,
  input  logic                        rd_en,
  input  logic [kwsv_pkg::IDX_W-1:0]  rd_idx,
  output logic [kwsv_pkg::TICK_W-1:0] rd_tick
);
  import kwsv_pkg::*;

  logic [TICK_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [TICK_W-1:0] rd_data;
  logic              rd_valid;
  logic [AW-1:0]     wa;
  logic [AW-1:0]     ra;
  logic              bypass;

  assign wa     = wr.idx[AW-1:0];
  assign ra     = rd_idx[AW-1:0];
  assign bypass = wr.en && (wa == ra);

  // storage array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.tick;
    end
  end

  // registered read with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= bypass ? wr.tick : mem[ra];
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wa] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= bypass || valid[ra];
      end
    end
  end

  assign rd_tick = rd_valid ? rd_data : '0;

endmodule

// ===== design/kwsv_checker.sv =====
// ----------------------------------------------------------------------------
// kwsv_checker
// Port-level checks on the keyword score vote gate result stream.
// ----------------------------------------------------------------------------
module kwsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import kwsv_pkg::*;

  // a firing is always a detection
  a_fired_needs_detect: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> m_tdata[14])
    else $error("fired without detected");

  // keyword zero never detects
  a_detect_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> m_tdata[5:0] != '0)
    else $error("detection on keyword zero");

  // percentage stays in range
  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[22:16] <= PCT_SCALE)
    else $error("confidence above 100");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed under stall");

endmodule

bind keyword_score_vote_gate kwsv_checker u_kwsv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/keyword_score_vote_gate_tb.sv =====
// ----------------------------------------------------------------------------
// keyword_score_vote_gate_tb
// Streams frames of keyword scores into the vote gate and checks every result
// beat against a cycle-free model of argmax, vote, threshold and cooldown.
// A few directed frames open the run. Randomized phases follow, each with its
// own register setting and flow-control mix. Most frames come in streaks that
// agree on one winner so that votes complete; noise and flat frames are mixed
// in to break streaks.
// ----------------------------------------------------------------------------
module keyword_score_vote_gate_tb;
  import kwsv_pkg::*;

  localparam int NKW          = NUM_KEYWORDS_DEF;
  localparam int PHASES       = 8;
  localparam int PHASE_FRAMES = 18;
  localparam int MAX_PRINTS   = 30;

  // unmapped register index, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one expected result beat
  typedef struct {
    logic [IDX_W-1:0]   top_index;
    logic [SCORE_W-1:0] top_score;
    logic               detected;
    logic               fired;
    logic [CONF_W-1:0]  conf;
  } verdict_t;

  // vote model plus queue of verdicts still owed by the block
  class gate_scoreboard;
    logic [SCORE_W-1:0] thr;
    logic [TRIG_W-1:0]  trig;
    logic [TICK_W-1:0]  cool;
    int unsigned        pos;
    logic [SCORE_W-1:0] run_max;
    logic [IDX_W-1:0]   run_idx;
    logic [IDX_W-1:0]   target;
    logic               started;
    logic [TRIG_W-1:0]  count;
    logic [TICK_W-1:0]  stamp [NKW];
    verdict_t           pending_verdicts [$];
    int                 errors;
    int                 checked;
    int                 detections;
    int                 firings;

    function new();
      thr        = THRESH_RESET;
      trig       = TRIGGER_RESET;
      cool       = COOLDOWN_RESET;
      pos        = 0;
      run_max    = '0;
      run_idx    = '0;
      target     = '0;
      started    = 1'b0;
      count      = '0;
      foreach (stamp[k]) stamp[k] = '0;
      errors     = 0;
      checked    = 0;
      detections = 0;
      firings    = 0;
    endfunction

    // register write, unknown index ignored
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_THRESHOLD: thr = val[SCORE_W-1:0];
        REG_TRIGGER:   trig = val[TRIG_W-1:0];
        REG_COOLDOWN:  cool = val;
        default: ;
      endcase
    endfunction

    // one accepted score beat, last beat of a frame queues a verdict
    function void take_score(logic [SCORE_W-1:0] s, logic [TICK_W-1:0] now);
      verdict_t          v;
      logic [TICK_W-1:0] elapsed;
      if (pos == 0 || pos >= NKW) begin
        pos     = 0;
        run_max = '0;
        run_idx = '0;
      end
      // first strict maximum wins
      if (s > run_max) begin
        run_max = s;
        run_idx = IDX_W'(pos);
      end
      if (pos + 1 < NKW) begin
        pos++;
        return;
      end
      pos         = 0;
      v.top_index = run_idx;
      v.top_score = run_max;
      v.detected  = 1'b0;
      v.fired     = 1'b0;
      v.conf      = CONF_W'((int'(run_max) * 100 + 127) / 255);
      // consecutive-frame vote
      if (!started || run_idx == target) begin
        if (!started) begin
          target  = run_idx;
          started = 1'b1;
        end
        count = count + 1'b1;
        if (count >= trig) begin
          count   = '0;
          started = 1'b0;
          if (run_idx != 0 && run_max >= thr) begin
            v.detected = 1'b1;
            detections++;
            // wrap-safe cooldown per keyword
            elapsed = now - stamp[run_idx];
            if (elapsed >= cool) begin
              stamp[run_idx] = now;
              v.fired        = 1'b1;
              firings++;
            end
          end
        end
      end else begin
        count  = TRIG_W'(1);
        target = run_idx;
      end
      pending_verdicts.push_back(v);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // one accepted result beat against the oldest verdict
    task check_verdict(logic [23:0] d);
      verdict_t e;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result beat %h with no frame outstanding", d));
        return;
      end
      e = pending_verdicts.pop_front();
      checked++;
      if (d[5:0] !== e.top_index)
        report($sformatf("top_index got %0d want %0d", d[5:0], e.top_index));
      if (d[13:6] !== e.top_score)
        report($sformatf("top_score got %0d want %0d", d[13:6], e.top_score));
      if (d[14] !== e.detected)
        report($sformatf("detected got %b want %b", d[14], e.detected));
      if (d[15] !== e.fired)
        report($sformatf("fired got %b want %b", d[15], e.fired));
      if (d[22:16] !== e.conf)
        report($sformatf("score_pct got %0d want %0d", d[22:16], e.conf));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [39:0]           s_tdata;   // score[7:0], now_tick[39:8]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;   // top_index[5:0], top_score[13:6], detected[14],
                                    // fired[15], score_pct[22:16], zero[23]

  int                    src_idle_pct  = 0;
  int                    snk_stall_pct = 0;
  int                    frames_sent   = 0;
  logic [SCORE_W-1:0]    frame_sc [NKW];
  logic [TICK_W-1:0]     tick;
  logic [SCORE_W-1:0]    cur_thr;
  logic [TRIG_W-1:0]     cur_trig;
  gate_scoreboard        sb = new();

  keyword_score_vote_gate #(.NUM_KEYWORDS(NKW)) dut (.*);

  always #5 clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("keyword_score_vote_gate test failed");
    $finish;
  end

  // one score beat, with random idle cycles ahead of it
  task automatic send_beat(logic [SCORE_W-1:0] s, logic [TICK_W-1:0] now);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, s};
    do @(posedge clk); while (!s_tready);
    sb.take_score(s, now);
  endtask

  // whole frame, tick only matters on the last beat
  task automatic send_frame(logic [TICK_W-1:0] now);
    for (int k = 0; k < NKW; k++)
      send_beat(frame_sc[k], (k == NKW - 1) ? now : TICK_W'($urandom));
    frames_sent++;
  endtask

  // frame won by keyword w unless ws is zero, later ties must lose
  function automatic void build_win(int w, logic [SCORE_W-1:0] ws);
    for (int k = 0; k < NKW; k++)
      if (k == w) frame_sc[k] = ws;
      else if (ws == 0) frame_sc[k] = '0;
      else if (k > w && $urandom_range(0, 7) == 0) frame_sc[k] = ws;
      else frame_sc[k] = SCORE_W'($urandom_range(0, ws - 1));
  endfunction

  function automatic void fill_flat(logic [SCORE_W-1:0] v);
    foreach (frame_sc[k]) frame_sc[k] = v;
  endfunction

  // register write, enable stays up for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // all registers, junk in the unused upper data bits
  task automatic program_regs(logic [SCORE_W-1:0] thr, logic [TRIG_W-1:0] trig,
                              logic [TICK_W-1:0] cool);
    logic [CFG_DATA_W-1:0] val;
    val = $urandom;
    val[SCORE_W-1:0] = thr;
    write_reg(REG_THRESHOLD, val);
    val = $urandom;
    val[TRIG_W-1:0] = trig;
    write_reg(REG_TRIGGER, val);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_SPARE, $urandom);
    cfg_we   <= 1'b0;
    cur_thr  = thr;
    cur_trig = trig;
  endtask

  // wait out every owed result, then the pipeline tail
  task automatic drain(int settle);
    s_tvalid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // result side with random stalls
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
    end
  end

  // stimulus
  initial begin
    int                 w;
    int                 roll;
    int                 start;
    int                 streak_left;
    logic [SCORE_W-1:0] ws;
    logic [TICK_W-1:0]  cool;
    w           = 0;
    streak_left = 0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-frame votes against reset timestamps
    program_regs(THRESH_RESET, 4'd1, COOLDOWN_RESET);
    fill_flat(8'd0);
    send_frame(32'd5);                // all zero, keyword 0 wins
    build_win(NKW - 1, 8'd255);
    send_frame(32'd10);               // detected, blocked by zero timestamp
    build_win(NKW - 1, 8'd255);
    send_frame(32'd1000);             // cooldown just met, fires
    drain(6);

    // random phases, each with its own setting and flow-control mix
    tick = 32'd2000;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(8'd0, 4'd0, 32'd0);
        1: program_regs(8'd255, 4'd15, 32'hFFFF_FFFF);
        2: program_regs(THRESH_RESET, TRIGGER_RESET, COOLDOWN_RESET);
        default: begin
          cool = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom) :
                 TICK_W'($urandom_range(0, 3000));
          program_regs(SCORE_W'($urandom_range(0, 255)), TRIG_W'($urandom_range(0, 15)),
                       cool);
        end
      endcase
      src_idle_pct  = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 14 : 0;
      snk_stall_pct = (p % 4 == 2) ? 45 : (p % 4 == 3) ? 14 : 0;
      // run the tick across the 32-bit wrap
      if (p % 3 == 2) tick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      start = frames_sent;
      while (frames_sent - start < PHASE_FRAMES) begin
        roll = $urandom_range(0, 99);
        // agreeing streak, mostly on a nonzero keyword
        if (streak_left == 0 && roll < 70) begin
          w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, NKW - 1);
          streak_left = $urandom_range(1, int'(cur_trig) + 2);
        end
        if (streak_left > 0) begin
          ws = $urandom_range(0, 1) ? SCORE_W'($urandom_range(cur_thr, 255)) :
               SCORE_W'($urandom_range(0, 255));
          build_win(w, ws);
          streak_left--;
        end else if (roll < 88) begin
          foreach (frame_sc[k]) frame_sc[k] = SCORE_W'($urandom);
        end else begin
          fill_flat((roll < 94) ? 8'd0 : SCORE_W'($urandom));
        end
        tick = tick + $urandom_range(0, 600);
        if ($urandom_range(0, 19) == 0) tick = $urandom;
        send_frame(tick);
      end
      drain(6);
    end

    drain(10);
    $display("sent %0d frames over %0d register settings and four flow-control mixes",
             frames_sent, PHASES + 1);
    $display("checked %0d results with %0d detections and %0d firings, %0d mismatches",
             sb.checked, sb.detections, sb.firings, sb.errors);
    if (sb.errors == 0) begin
      $display("keyword_score_vote_gate test passed");
    end else begin
      $display("keyword_score_vote_gate test failed");
    end
    $finish;
  end

endmodule
